// ===== rtl/core/dlr_pkg.sv =====
`timescale 1ns / 1ps

package dlr_pkg;

   localparam int COORD_BITS = 12;
   // The decision term reaches twice the larger delta in magnitude.
   localparam int DEC_BITS   = COORD_BITS + 3;
   localparam int COUNT_BITS = COORD_BITS + 1;
   localparam int DASH_BITS  = 8;

   localparam logic [DASH_BITS-1:0] DASH_RESET = DASH_BITS'(5);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef struct packed {
      logic                          operation;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic                          visible;
      logic                          last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [DEC_BITS-1:0]   decision;
      logic [COORD_BITS-1:0] delta_x;
      logic [COORD_BITS-1:0] delta_y;
      logic                  step_x_negative;
      logic                  step_y_negative;
      logic                  x_major;
      logic [COUNT_BITS-1:0] pixels_left;
      logic [DASH_BITS-1:0]  dash_count;
      logic                  dash_off;
      logic                  line_active;
   } line_state_type;

endpackage

// ===== rtl/core/dlr_setup.sv =====
`timescale 1ns / 1ps

module dlr_setup (
   input  dlr_pkg::req_type        req,
   output dlr_pkg::line_state_type state
);

   logic [dlr_pkg::COORD_BITS:0]   diff_x;
   logic [dlr_pkg::COORD_BITS:0]   diff_y;
   logic [dlr_pkg::COORD_BITS:0]   abs_x;
   logic [dlr_pkg::COORD_BITS:0]   abs_y;
   logic [dlr_pkg::COORD_BITS-1:0] d_maj;
   logic [dlr_pkg::COORD_BITS-1:0] d_min;
   logic                            x_major;

   always_comb begin
      diff_x = {req.x_end[dlr_pkg::COORD_BITS-1], req.x_end}
             - {req.x_start[dlr_pkg::COORD_BITS-1], req.x_start};
      diff_y = {req.y_end[dlr_pkg::COORD_BITS-1], req.y_end}
             - {req.y_start[dlr_pkg::COORD_BITS-1], req.y_start};
      abs_x = diff_x[dlr_pkg::COORD_BITS] ? -diff_x : diff_x;
      abs_y = diff_y[dlr_pkg::COORD_BITS] ? -diff_y : diff_y;
      // Equal deltas step along y.
      x_major = abs_x[dlr_pkg::COORD_BITS-1:0] > abs_y[dlr_pkg::COORD_BITS-1:0];
      d_maj = x_major ? abs_x[dlr_pkg::COORD_BITS-1:0] : abs_y[dlr_pkg::COORD_BITS-1:0];
      d_min = x_major ? abs_y[dlr_pkg::COORD_BITS-1:0] : abs_x[dlr_pkg::COORD_BITS-1:0];

      state.cur_x           = req.x_start;
      state.cur_y           = req.y_start;
      state.decision        = {2'b00, d_min, 1'b0} - {3'b000, d_maj};
      state.delta_x         = abs_x[dlr_pkg::COORD_BITS-1:0];
      state.delta_y         = abs_y[dlr_pkg::COORD_BITS-1:0];
      state.step_x_negative = diff_x[dlr_pkg::COORD_BITS];
      state.step_y_negative = diff_y[dlr_pkg::COORD_BITS];
      state.x_major         = x_major;
      state.pixels_left     = {1'b0, d_maj} + dlr_pkg::COUNT_BITS'(1);
      state.dash_count      = '0;
      state.dash_off        = 1'b0;
      state.line_active     = 1'b1;
   end

endmodule

// ===== rtl/core/dlr_walk.sv =====
`timescale 1ns / 1ps

module dlr_walk (
   input  dlr_pkg::line_state_type       state,
   input  logic [dlr_pkg::DASH_BITS-1:0] dash_length,
   output dlr_pkg::line_state_type       state_next,
   output dlr_pkg::rsp_type              pixel
);

   logic [dlr_pkg::COORD_BITS-1:0] d_maj;
   logic [dlr_pkg::COORD_BITS-1:0] d_min;
   logic [dlr_pkg::COORD_BITS-1:0] inc_x;
   logic [dlr_pkg::COORD_BITS-1:0] inc_y;
   logic [dlr_pkg::DEC_BITS-1:0]   twice_min;
   logic [dlr_pkg::DEC_BITS-1:0]   twice_maj;
   logic [dlr_pkg::DASH_BITS-1:0]  run_len;
   logic [dlr_pkg::DASH_BITS-1:0]  count_inc;
   logic                            dec_neg;
   logic                            move_x;
   logic                            move_y;
   logic                            run_end;
   logic                            is_last;

   always_comb begin
      d_maj     = state.x_major ? state.delta_x : state.delta_y;
      d_min     = state.x_major ? state.delta_y : state.delta_x;
      twice_min = {2'b00, d_min, 1'b0};
      twice_maj = {2'b00, d_maj, 1'b0};
      dec_neg   = state.decision[dlr_pkg::DEC_BITS-1];
      // The major axis always moves; the minor one only on a non-negative term.
      move_x    = state.x_major | ~dec_neg;
      move_y    = ~state.x_major | ~dec_neg;
      inc_x     = state.step_x_negative ? '1 : dlr_pkg::COORD_BITS'(1);
      inc_y     = state.step_y_negative ? '1 : dlr_pkg::COORD_BITS'(1);
      run_len   = (dash_length == '0) ? dlr_pkg::DASH_BITS'(1) : dash_length;
      count_inc = state.dash_count + dlr_pkg::DASH_BITS'(1);
      run_end   = (count_inc >= run_len) || (count_inc == '0);
      is_last   = (state.pixels_left[dlr_pkg::COUNT_BITS-1:1] == '0);

      state_next          = state;
      state_next.cur_x    = move_x ? state.cur_x + inc_x : state.cur_x;
      state_next.cur_y    = move_y ? state.cur_y + inc_y : state.cur_y;
      state_next.decision = dec_neg ? state.decision + twice_min
                                    : state.decision + twice_min - twice_maj;
      state_next.dash_count  = run_end ? '0 : count_inc;
      state_next.dash_off    = run_end ? ~state.dash_off : state.dash_off;
      state_next.pixels_left = is_last ? '0
                             : state.pixels_left - dlr_pkg::COUNT_BITS'(1);
      state_next.line_active = ~is_last;

      pixel.pixel_x = state.cur_x;
      pixel.pixel_y = state.cur_y;
      pixel.visible = ~state.dash_off;
      pixel.last    = is_last;
   end

endmodule

// ===== rtl/core/dlr_out_buf.sv =====
`timescale 1ns / 1ps

module dlr_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dlr_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dlr_pkg::rsp_type rsp_payload
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   dlr_pkg::rsp_type out_data_ff, out_data_in;
   dlr_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             take;

   // The skid entry fills only while the output beat is held, so a push never
   // arrives while it is occupied.
   always_comb begin
      take          = out_valid_ff & ~rsp_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         out_valid_in  = skid_valid_ff | push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

// ===== rtl/core/dashed_line_rasterizer_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// req       in         req_valid / req_stall         dlr_pkg::req_type
// rsp       out        rsp_valid / rsp_stall         dlr_pkg::rsp_type
// csr       in         csr_write_enable (no wait)    csr_write_data, dash length
//
// One input beat is taken every cycle while req_stall is low; a step on an
// active line produces its pixel on rsp, and a start produces nothing.
// Synchronous reset returns the block to idle with a dash length of five.
// An output register plus one skid entry absorb rsp_stall; req_stall rises
// only when both are occupied.

module dashed_line_rasterizer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dlr_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dlr_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [dlr_pkg::DASH_BITS-1:0] csr_write_data
);

   logic [dlr_pkg::DASH_BITS-1:0] dash_length_ff;
   dlr_pkg::line_state_type       state_ff, state_in;
   dlr_pkg::line_state_type       start_state;
   dlr_pkg::line_state_type       walk_state;
   dlr_pkg::rsp_type              walk_pixel;
   logic                          accept;
   logic                          push;
   logic                          buf_full;

   dlr_setup u_setup (
      .req   (req_payload),
      .state (start_state)
   );

   dlr_walk u_walk (
      .state       (state_ff),
      .dash_length (dash_length_ff),
      .state_next  (walk_state),
      .pixel       (walk_pixel)
   );

   dlr_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (walk_pixel),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = buf_full;
   assign accept    = req_valid & ~buf_full;
   assign push      = accept & (req_payload.operation == dlr_pkg::OP_STEP)
                    & state_ff.line_active;

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (req_payload.operation == dlr_pkg::OP_START) begin
            state_in = start_state;
         end else if (state_ff.line_active) begin
            state_in = walk_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '0;
         dash_length_ff <= dlr_pkg::DASH_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            dash_length_ff <= csr_write_data;
         end
      end
   end

endmodule

// ===== rtl/core/dlr_checker.sv =====
`timescale 1ns / 1ps

module dlr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dlr_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dlr_pkg::rsp_type rsp_payload
);

   // A held result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // Reset leaves nothing to deliver and the input open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // With the output empty, a single push cannot fill both buffer entries.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall)
      else $error("input stalled with an empty output");

   // A start beat never produces a pixel.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall
      && (req_payload.operation == dlr_pkg::OP_START) |=> !rsp_valid)
      else $error("start beat produced a result");

endmodule

bind dashed_line_rasterizer_core dlr_checker u_dlr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/dashed_line_rasterizer_core_test.sv =====
`timescale 1ns / 1ps

module dashed_line_rasterizer_core_test;

   localparam int CYCLE_LIMIT = 300000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   dlr_pkg::req_type              req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   dlr_pkg::rsp_type              rsp_payload;
   logic                          csr_write_enable = 1'b0;
   logic [dlr_pkg::DASH_BITS-1:0] csr_write_data = '0;

   int idle_send_pct = 0;
   int stall_rsp_pct = 0;
   int rsp_hold_cycles = 0;
   int cycle_count = 0;
   int mismatch_count = 0;

   // Line walker mirrored from the block, updated as each beat is accepted.
   logic [dlr_pkg::DASH_BITS-1:0]         dash_len_reg = dlr_pkg::DASH_RESET;
   logic signed [dlr_pkg::COORD_BITS-1:0] ln_x = '0;
   logic signed [dlr_pkg::COORD_BITS-1:0] ln_y = '0;
   int                                    ln_err = 0;
   int                                    ln_dx = 0;
   int                                    ln_dy = 0;
   logic                                  ln_sx_neg = 1'b0;
   logic                                  ln_sy_neg = 1'b0;
   logic                                  ln_x_major = 1'b0;
   int                                    ln_remaining = 0;
   logic [dlr_pkg::DASH_BITS-1:0]         run_pos = '0;
   logic                                  in_gap = 1'b0;
   logic                                  drawing = 1'b0;

   dlr_pkg::rsp_type expected_pixels[$];
   dlr_pkg::rsp_type next_pixel;

   dashed_line_rasterizer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic void predict_pixel(input dlr_pkg::req_type beat);
      int               x1;
      int               y1;
      int               x2;
      int               y2;
      int               run_len;
      dlr_pkg::rsp_type px;
      if (beat.operation == dlr_pkg::OP_START) begin
         x1 = beat.x_start;
         y1 = beat.y_start;
         x2 = beat.x_end;
         y2 = beat.y_end;
         ln_dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
         ln_dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
         ln_sx_neg = (x2 < x1);
         ln_sy_neg = (y2 < y1);
         // Equal deltas walk along y.
         ln_x_major = (ln_dx > ln_dy);
         ln_err = ln_x_major ? 2 * ln_dy - ln_dx : 2 * ln_dx - ln_dy;
         ln_remaining = (ln_x_major ? ln_dx : ln_dy) + 1;
         ln_x = beat.x_start;
         ln_y = beat.y_start;
         run_pos = '0;
         in_gap = 1'b0;
         drawing = 1'b1;
      end else if (drawing) begin
         run_len = (dash_len_reg == 0) ? 1 : int'(dash_len_reg);
         px.pixel_x = ln_x;
         px.pixel_y = ln_y;
         px.visible = !in_gap;
         px.last = (ln_remaining <= 1);
         expected_pixels.push_back(px);
         if (ln_x_major) begin
            ln_x = ln_sx_neg ? ln_x - dlr_pkg::COORD_BITS'(1)
                             : ln_x + dlr_pkg::COORD_BITS'(1);
            if (ln_err < 0) begin
               ln_err += 2 * ln_dy;
            end else begin
               ln_y = ln_sy_neg ? ln_y - dlr_pkg::COORD_BITS'(1)
                                : ln_y + dlr_pkg::COORD_BITS'(1);
               ln_err += 2 * (ln_dy - ln_dx);
            end
         end else begin
            ln_y = ln_sy_neg ? ln_y - dlr_pkg::COORD_BITS'(1)
                             : ln_y + dlr_pkg::COORD_BITS'(1);
            if (ln_err < 0) begin
               ln_err += 2 * ln_dx;
            end else begin
               ln_x = ln_sx_neg ? ln_x - dlr_pkg::COORD_BITS'(1)
                                : ln_x + dlr_pkg::COORD_BITS'(1);
               ln_err += 2 * (ln_dx - ln_dy);
            end
         end
         // A shortened dash length ends the current run at once.
         run_pos = run_pos + 1'b1;
         if (run_pos >= run_len || run_pos == 0) begin
            run_pos = '0;
            in_gap = !in_gap;
         end
         if (px.last) begin
            ln_remaining = 0;
            drawing = 1'b0;
         end else begin
            ln_remaining--;
         end
      end
   endfunction

   // Both channels are sampled on the values held just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel at (%0d, %0d)", rsp_payload.pixel_x,
                      rsp_payload.pixel_y);
               mismatch_count++;
            end else begin
               next_pixel = expected_pixels.pop_front();
               if (rsp_payload.pixel_x !== next_pixel.pixel_x) begin
                  $error("pixel_x: expected %0d, actual %0d", next_pixel.pixel_x,
                         rsp_payload.pixel_x);
                  mismatch_count++;
               end
               if (rsp_payload.pixel_y !== next_pixel.pixel_y) begin
                  $error("pixel_y: expected %0d, actual %0d", next_pixel.pixel_y,
                         rsp_payload.pixel_y);
                  mismatch_count++;
               end
               if (rsp_payload.visible !== next_pixel.visible) begin
                  $error("visible: expected %0d, actual %0d", next_pixel.visible,
                         rsp_payload.visible);
                  mismatch_count++;
               end
               if (rsp_payload.last !== next_pixel.last) begin
                  $error("last: expected %0d, actual %0d", next_pixel.last,
                         rsp_payload.last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_pixel(req_payload);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_rsp_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** dashed_line_rasterizer_core: FAILED **");
         $finish;
      end
   end

   function automatic dlr_pkg::req_type make_start(input int x1, input int y1, input int x2,
                                                   input int y2);
      dlr_pkg::req_type beat;
      beat.operation = dlr_pkg::OP_START;
      beat.x_start = dlr_pkg::COORD_BITS'(x1);
      beat.y_start = dlr_pkg::COORD_BITS'(y1);
      beat.x_end = dlr_pkg::COORD_BITS'(x2);
      beat.y_end = dlr_pkg::COORD_BITS'(y2);
      return beat;
   endfunction

   // The endpoint fields of a step are ignored, so they carry noise.
   function automatic dlr_pkg::req_type step_beat();
      dlr_pkg::req_type beat;
      beat = dlr_pkg::req_type'($bits(dlr_pkg::req_type)'({$urandom, $urandom}));
      beat.operation = dlr_pkg::OP_STEP;
      return beat;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int near_coord(input int c);
      int v;
      v = c + int'($urandom_range(40)) - 20;
      if (v > 2047) begin
         v = 2047;
      end
      if (v < -2048) begin
         v = -2048;
      end
      return v;
   endfunction

   // Valid stays high from one accepted beat to the next unless an idle gap
   // is drawn, so it is never lowered and raised in the same step.
   task automatic send_beat(input dlr_pkg::req_type beat);
      while ($urandom_range(99) < idle_send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   // A start beat yields no pixel, so a few spare cycles follow the last one.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_dash_length(input logic [dlr_pkg::DASH_BITS-1:0] len);
      drain_pixels();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dash_len_reg = len;
      @(posedge clock);
   endtask

   task automatic test_idle_step();
      send_beat(step_beat());
   endtask

   task automatic test_single_pixel();
      send_beat(make_start(-2048, 2047, -2048, 2047));
      send_beat(step_beat());
      send_beat(step_beat());
   endtask

   task automatic test_extreme_restart();
      send_beat(make_start(-2048, -2048, 2047, 2046));
      repeat (2) send_beat(step_beat());
      send_beat(make_start(2047, -2048, -2048, 2047));
      repeat (2) send_beat(step_beat());
      send_beat(make_start(2047, 2047, 2045, 2046));
      repeat (3) send_beat(step_beat());
   endtask

   task automatic test_dash_change();
      set_dash_length(8'd3);
      send_beat(make_start(10, -5, 20, -3));
      repeat (2) send_beat(step_beat());
      set_dash_length(8'd1);
      repeat (2) send_beat(step_beat());
      set_dash_length(8'd0);
      repeat (2) send_beat(step_beat());
   endtask

   // The receiver holds off long enough for the output register and the skid
   // entry to fill, so the block has to stall its input.
   task automatic test_output_hold_off();
      idle_send_pct = 0;
      stall_rsp_pct = 0;
      set_dash_length(8'd4);
      send_beat(make_start(-100, 40, 150, -60));
      rsp_hold_cycles = 200;
      repeat (40) send_beat(step_beat());
      drain_pixels();
   endtask

   task automatic run_random_lines(input int beats, input int send_pct, input int stall_pct);
      int x1;
      int y1;
      int x2;
      int y2;
      int dx;
      int dy;
      int span;
      int walk;
      int sent;
      int cfg_at;
      idle_send_pct = send_pct;
      stall_rsp_pct = stall_pct;
      sent = 0;
      cfg_at = 0;
      while (sent < beats) begin
         x1 = rand_coord();
         y1 = rand_coord();
         if ($urandom_range(7) == 0) begin
            x2 = rand_coord();
            y2 = rand_coord();
         end else begin
            x2 = near_coord(x1);
            y2 = near_coord(y1);
         end
         dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
         dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
         span = ((dx > dy) ? dx : dy) + 1;
         // Long lines are only walked a short way before the next start.
         if (span > 40) begin
            walk = $urandom_range(1, 30);
         end else if (span > 1 && $urandom_range(5) == 0) begin
            walk = $urandom_range(1, span - 1);
         end else begin
            walk = span;
         end
         send_beat(make_start(x1, y1, x2, y2));
         sent++;
         for (int i = 0; i < walk; i++) begin
            if (sent >= cfg_at) begin
               case ($urandom_range(5))
                  0: set_dash_length(8'd0);
                  1: set_dash_length(8'd1);
                  2: set_dash_length(8'd255);
                  3: set_dash_length(dlr_pkg::DASH_BITS'($urandom_range(2, 4)));
                  default: set_dash_length(dlr_pkg::DASH_BITS'($urandom_range(255)));
               endcase
               cfg_at = sent + $urandom_range(80, 200);
            end
            send_beat(step_beat());
            sent++;
         end
         if (walk == span && $urandom_range(3) == 0) begin
            send_beat(step_beat());
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_send_pct = 7;
      stall_rsp_pct = 62;
      test_idle_step();
      test_single_pixel();
      test_extreme_restart();
      test_dash_change();
      test_output_hold_off();
      run_random_lines(700, 7, 62);
      run_random_lines(700, 62, 7);
      run_random_lines(700, 0, 0);
      drain_pixels();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("** dashed_line_rasterizer_core: PASSED **");
      end else begin
         $display("** dashed_line_rasterizer_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/dlr_pkg.sv
rtl/core/dlr_setup.sv
rtl/core/dlr_walk.sv
rtl/core/dlr_out_buf.sv
rtl/core/dashed_line_rasterizer_core.sv
rtl/core/dlr_checker.sv
tb/dashed_line_rasterizer_core_test.sv
